FILE: rtl/core/brss_pkg.sv
// ----------------------------------------------------------------------------
// brss_pkg
// Shared types and constants of the block range-sum store: command format
// passed from the front end to the back end, and the back-end state codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brss_pkg;

	localparam int POS_W        = 10;
	localparam int DELTA_W      = 16;
	localparam int SUM_W        = 32;
	localparam int DEPTH_DEF    = 1024;
	localparam int BLK_SIZE_DEF = 32;
	localparam int QDEPTH       = 2;
	localparam int QAW          = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		KIND_ADD,
		KIND_QUERY,
		KIND_ZERO
	} brss_kind_t;

	// idx_a is the add position or the query low index, idx_b the clamped high index
	typedef struct packed {
		brss_kind_t                 kind;
		logic [POS_W-1:0]           idx_a;
		logic [POS_W-1:0]           idx_b;
		logic signed [DELTA_W-1:0]  delta;
	} brss_cmd_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_ADD_RD,
		BK_ADD_WR,
		BK_QRY,
		BK_QFIN
	} brss_state_t;

endpackage

FILE: rtl/core/brss_front.sv
// ----------------------------------------------------------------------------
// brss_front
// Input stage: registers an accepted item, clamps the query range against
// the table depth and turns the item into a command for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brss_front #(
	parameter int DEPTH = brss_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               hold,
	input  logic                               start,
	output logic                               busy,
	input  logic                               req_type,
	input  logic [brss_pkg::POS_W-1:0]         position,
	input  logic signed [brss_pkg::DELTA_W-1:0] delta,
	input  logic [brss_pkg::POS_W-1:0]         range_low,
	input  logic [brss_pkg::POS_W-1:0]         range_high,
	output logic                               push,
	output brss_pkg::brss_cmd_t                push_cmd,
	input  logic                               full
);
	import brss_pkg::*;

	logic                       v_s1;
	logic                       req_s1;
	logic [POS_W-1:0]           pos_s1;
	logic signed [DELTA_W-1:0]  delta_s1;
	logic [POS_W-1:0]           lo_s1;
	logic [POS_W-1:0]           hi_s1;
	logic [POS_W-1:0]           hi_cl;
	logic                       accept;
	logic                       keep;

	assign busy   = hold || (v_s1 && full);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (v_s1 && !full) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1   <= req_type;
			pos_s1   <= position;
			delta_s1 <= delta;
			lo_s1    <= range_low;
			hi_s1    <= range_high;
		end
	end

	// high index past the table end is pulled back to the last entry
	assign hi_cl = (32'(hi_s1) >= 32'(DEPTH)) ? POS_W'(DEPTH - 1) : hi_s1;

	always_comb begin
		push_cmd.idx_a = pos_s1;
		push_cmd.idx_b = hi_cl;
		push_cmd.delta = delta_s1;
		push_cmd.kind  = KIND_ADD;
		keep           = 1'b1;
		if (!req_s1) begin
			// an add beyond the table is dropped
			keep = 32'(pos_s1) < 32'(DEPTH);
		end else if ((32'(lo_s1) >= 32'(DEPTH)) || (lo_s1 > hi_cl)) begin
			push_cmd.kind  = KIND_ZERO;
			push_cmd.idx_a = lo_s1;
		end else begin
			push_cmd.kind  = KIND_QUERY;
			push_cmd.idx_a = lo_s1;
		end
	end

	assign push = v_s1 && !full && keep;

endmodule

FILE: rtl/core/brss_queue.sv
// ----------------------------------------------------------------------------
// brss_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brss_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  brss_pkg::brss_cmd_t push_cmd,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output brss_pkg::brss_cmd_t head
);
	import brss_pkg::*;

	brss_cmd_t        slot_q [QDEPTH];
	logic [QAW-1:0]   wr_q;
	logic [QAW-1:0]   rd_q;
	logic [QAW:0]     cnt_q;

	assign full  = cnt_q == (QAW+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == QDEPTH - 1) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (32'(rd_q) == QDEPTH - 1) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue pop while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= QDEPTH) else $error("queue count out of range");

endmodule

FILE: rtl/core/brss_back.sv
// ----------------------------------------------------------------------------
// brss_back
// Execution stage: holds the entry memory and the block-sum memory, clears
// them after reset, applies adds by read-modify-write and walks queries one
// read per cycle, taking a block sum wherever a whole block fits the range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brss_back #(
	parameter int DEPTH      = brss_pkg::DEPTH_DEF,
	parameter int BLOCK_SIZE = brss_pkg::BLK_SIZE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	output logic                              clearing,
	input  logic                              empty,
	input  brss_pkg::brss_cmd_t               head,
	output logic                              pop,
	output logic                              done,
	output logic signed [brss_pkg::SUM_W-1:0] range_sum
);
	import brss_pkg::*;

	localparam int NBLK = (DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int AW   = $clog2(DEPTH);
	localparam int NBW  = (NBLK > 1) ? $clog2(NBLK) : 1;
	localparam int BSH  = $clog2(BLOCK_SIZE);
	localparam int IW   = POS_W + 1;

	logic [SUM_W-1:0]  emem [DEPTH];
	logic [SUM_W-1:0]  bmem [NBLK];

	brss_state_t       state_q, state_nxt;
	brss_cmd_t         cmd_q;
	logic [AW-1:0]     clr_q;
	logic [IW-1:0]     i_q;
	logic [SUM_W-1:0]  acc_q;
	logic              pend_s1;
	logic              blk_s1;
	logic [SUM_W-1:0]  edata_q;
	logic [SUM_W-1:0]  bdata_q;
	logic              done_q;
	logic [SUM_W-1:0]  range_sum_q;

	logic [POS_W-1:0]  rd_idx;
	logic              take_blk;
	logic [IW-1:0]     i_step;
	logic              last_issue;
	logic [SUM_W-1:0]  add_in;
	logic [SUM_W-1:0]  acc_nxt;
	logic [SUM_W-1:0]  dext;
	logic              e_we, b_we;
	logic [AW-1:0]     e_waddr;
	logic [NBW-1:0]    b_waddr;
	logic [SUM_W-1:0]  e_wdata, b_wdata;
	logic              out_set;
	logic [SUM_W-1:0]  out_val;
	logic              q_start;
	logic              q_run;

	assign clearing  = state_q == BK_CLEAR;
	assign done      = done_q;
	assign range_sum = range_sum_q;

	assign dext   = {{(SUM_W-DELTA_W){cmd_q.delta[DELTA_W-1]}}, cmd_q.delta};
	assign rd_idx = (state_q == BK_QRY) ? i_q[POS_W-1:0] : cmd_q.idx_a;

	// a block sum is used when the walk sits on a block start and the whole block fits
	assign take_blk = (i_q[BSH-1:0] == '0)
		&& ((i_q + IW'(BLOCK_SIZE - 1)) <= {1'b0, cmd_q.idx_b});
	assign i_step     = take_blk ? (i_q + IW'(BLOCK_SIZE)) : (i_q + 1'b1);
	assign last_issue = i_step > {1'b0, cmd_q.idx_b};
	assign add_in     = pend_s1 ? (blk_s1 ? bdata_q : edata_q) : '0;
	assign acc_nxt    = acc_q + add_in;

	always_comb begin
		state_nxt = state_q;
		pop       = 1'b0;
		e_we      = 1'b0;
		b_we      = 1'b0;
		e_waddr   = AW'(cmd_q.idx_a);
		b_waddr   = NBW'(cmd_q.idx_a >> BSH);
		e_wdata   = edata_q + dext;
		b_wdata   = bdata_q + dext;
		out_set   = 1'b0;
		out_val   = acc_nxt;
		q_start   = 1'b0;
		q_run     = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				e_we    = 1'b1;
				b_we    = 32'(clr_q) < NBLK;
				e_waddr = clr_q;
				b_waddr = NBW'(clr_q);
				e_wdata = '0;
				b_wdata = '0;
				if (32'(clr_q) == DEPTH - 1) begin
					state_nxt = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					unique case (head.kind)
						KIND_ADD: begin
							state_nxt = BK_ADD_RD;
						end
						KIND_QUERY: begin
							state_nxt = BK_QRY;
							q_start   = 1'b1;
						end
						KIND_ZERO: begin
							out_set = 1'b1;
							out_val = '0;
						end
						default: begin
							out_set = 1'b1;
							out_val = '0;
						end
					endcase
				end
			end
			BK_ADD_RD: begin
				state_nxt = BK_ADD_WR;
			end
			BK_ADD_WR: begin
				e_we      = 1'b1;
				b_we      = 1'b1;
				state_nxt = BK_IDLE;
			end
			BK_QRY: begin
				q_run = 1'b1;
				if (last_issue) begin
					state_nxt = BK_QFIN;
				end
			end
			BK_QFIN: begin
				out_set   = 1'b1;
				state_nxt = BK_IDLE;
			end
			default: begin
				state_nxt = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q   <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			pend_s1 <= q_run;
			done_q  <= out_set;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (q_start) begin
			i_q   <= {1'b0, head.idx_a};
			acc_q <= '0;
		end else if (q_run) begin
			i_q    <= i_step;
			blk_s1 <= take_blk;
			acc_q  <= acc_nxt;
		end
		if (out_set) begin
			range_sum_q <= out_val;
		end
	end

	// both memories are read every cycle; the walk picks which word it uses
	always_ff @(posedge clk) begin
		edata_q <= emem[AW'(rd_idx)];
		bdata_q <= bmem[NBW'(rd_idx >> BSH)];
		if (e_we) begin
			emem[e_waddr] <= e_wdata;
		end
		if (b_we) begin
			bmem[b_waddr] <= b_wdata;
		end
	end

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> $past(state_nxt) == BK_IDLE || state_q == BK_IDLE)
		else $error("command taken outside idle");
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == BK_QFIN || $past(state_q) == BK_IDLE)
		else $error("result strobe from unexpected state");
	a_no_wr_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_QRY |-> !e_we && !b_we)
		else $error("memory write during query walk");
	a_pend_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> $past(state_q) == BK_QRY)
		else $error("pending read without query issue");

endmodule

FILE: rtl/core/block_range_sum_store_core.sv
// An add passes through BK_IDLE, BK_ADD_RD and BK_ADD_WR, which writes both memories;
// a query walks one read per cycle in BK_QRY, up to 2*(BLOCK_SIZE-1) entries plus
// DEPTH/BLOCK_SIZE-2 block sums (92 at defaults), and its sum is strobed after BK_QFIN.
// The walk is bound by the single read port of the entry and block-sum memories.
// Reset: a clearing pass over every entry zeroes both memories, busy stays high meanwhile.
// Results are strobed on done for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// block_range_sum_store_core
// Point-update / range-sum store with per-block running sums: front end,
// command queue and memory back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_range_sum_store_core #(
	parameter int DEPTH      = brss_pkg::DEPTH_DEF,
	parameter int BLOCK_SIZE = brss_pkg::BLK_SIZE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               req_type,
	input  logic [brss_pkg::POS_W-1:0]         position,
	input  logic signed [brss_pkg::DELTA_W-1:0] delta,
	input  logic [brss_pkg::POS_W-1:0]         range_low,
	input  logic [brss_pkg::POS_W-1:0]         range_high,
	output logic                               done,
	output logic signed [brss_pkg::SUM_W-1:0]  range_sum
);
	import brss_pkg::*;

	logic       clearing;
	logic       push;
	brss_cmd_t  push_cmd;
	logic       full;
	logic       pop;
	logic       empty;
	brss_cmd_t  head;

	brss_front #(
		.DEPTH (DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold       (clearing),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.position   (position),
		.delta      (delta),
		.range_low  (range_low),
		.range_high (range_high),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full)
	);

	brss_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	brss_back #(
		.DEPTH      (DEPTH),
		.BLOCK_SIZE (BLOCK_SIZE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.done      (done),
		.range_sum (range_sum)
	);

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks block_range_sum_store_core with a directed table of adds and range
// queries, then about 1650 random items in three phases with different
// sender idling. Every range_sum is compared with a typed-in value or with a local model
// that keeps its own copy of the entries and of the per-block sums.
// ----------------------------------------------------------------------------

module testbench;

	import brss_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int BLK          = BLK_SIZE_DEF;
	localparam int NBLK         = (DEPTH + BLK - 1) / BLK;
	localparam int PHASE_ITEMS  = 550;
	localparam int DRAIN_CYCLES = 200;
	localparam int STALL_LIMIT  = 8000;

	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct {
		logic                req;
		logic [POS_W-1:0]    pos;
		logic [DELTA_W-1:0]  dlt;
		logic [POS_W-1:0]    lo;
		logic [POS_W-1:0]    hi;
		bit                  has_sum;
		logic [SUM_W-1:0]    sum;
	} stim_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic                       req_type;
	logic [POS_W-1:0]           position;
	logic signed [DELTA_W-1:0]  delta;
	logic [POS_W-1:0]           range_low;
	logic [POS_W-1:0]           range_high;
	logic                       done;
	logic signed [SUM_W-1:0]    range_sum;

	// typed-in result for the current directed row, if any
	bit                         cur_has_sum;
	logic [SUM_W-1:0]           cur_sum;

	logic [SUM_W-1:0]           entry_copy [0:DEPTH-1];
	logic [SUM_W-1:0]           block_copy [0:NBLK-1];
	logic [SUM_W-1:0]           pending_sums [$];
	stim_row_t                  directed_rows [$];
	int                         error_count;
	int                         stall_cycles;

	block_range_sum_store_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.position   (position),
		.delta      (delta),
		.range_low  (range_low),
		.range_high (range_high),
		.done       (done),
		.range_sum  (range_sum)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [SUM_W-1:0] range_total(input int unsigned lo,
			input int unsigned hi);
		int unsigned top;
		int unsigned blo;
		int unsigned bhi;
		int unsigned k;
		logic [SUM_W-1:0] acc;
		top = hi;
		if (top >= DEPTH) top = DEPTH - 1;
		if (lo >= DEPTH || lo > top) return '0;
		blo = lo / BLK;
		bhi = top / BLK;
		acc = '0;
		if (blo == bhi) begin
			for (k = lo; k <= top; k++) acc += entry_copy[k];
			return acc;
		end
		for (k = lo; k < (blo + 1) * BLK; k++) acc += entry_copy[k];
		for (k = blo + 1; k < bhi; k++) acc += block_copy[k];
		for (k = bhi * BLK; k <= top; k++) acc += entry_copy[k];
		return acc;
	endfunction

	function automatic stim_row_t add_row(input int unsigned p,
			input logic [DELTA_W-1:0] d);
		stim_row_t r;
		r.req     = REQ_ADD;
		r.pos     = POS_W'(p);
		r.dlt     = d;
		// range fields carry junk, the add must ignore them
		r.lo      = POS_W'(~p);
		r.hi      = POS_W'(p);
		r.has_sum = 1'b0;
		r.sum     = '0;
		return r;
	endfunction

	function automatic stim_row_t query_row(input int unsigned lo,
			input int unsigned hi, input int unsigned p,
			input logic [DELTA_W-1:0] d, input bit has_sum, input logic [SUM_W-1:0] s);
		stim_row_t r;
		r.req     = REQ_QUERY;
		r.pos     = POS_W'(p);
		r.dlt     = d;
		r.lo      = POS_W'(lo);
		r.hi      = POS_W'(hi);
		r.has_sum = has_sum;
		r.sum     = s;
		return r;
	endfunction

	task automatic stim_append(input stim_row_t r);
		directed_rows.insert(directed_rows.size(), r);
	endtask

	task automatic make_random_row(output stim_row_t r);
		int unsigned a;
		int unsigned b;
		int unsigned sel;
		logic [DELTA_W-1:0] d;
		int unsigned p;
		sel = $urandom_range(99);
		if (sel < 50) begin
			sel = $urandom_range(99);
			if (sel < 70)
				p = $urandom_range(DEPTH - 1);
			else if (sel < 85)
				p = $urandom_range(NBLK - 1) * BLK + ($urandom_range(1) ? BLK - 1 : 0);
			else
				p = $urandom_range(1) ? DEPTH - 1 : 0;
			sel = $urandom_range(99);
			if (sel < 60) begin
				d = DELTA_W'($urandom);
			end else if (sel < 80) begin
				case ($urandom_range(3))
					0: d = 16'h7FFF;
					1: d = 16'h8000;
					2: d = 16'hFFFF;
					default: d = 16'h0001;
				endcase
			end else begin
				d = DELTA_W'($urandom_range(15) - 8);
			end
			r = add_row(p, d);
			r.lo = POS_W'($urandom);
			r.hi = POS_W'($urandom);
		end else begin
			sel = $urandom_range(99);
			if (sel < 60) begin
				a = $urandom_range(DEPTH - 1);
				b = $urandom_range(DEPTH - 1);
				if (a > b) begin
					sel = a;
					a = b;
					b = sel;
				end
			end else if (sel < 80) begin
				// short range, within one block or across one or two block boundaries
				a = $urandom_range(DEPTH - 1);
				b = a + $urandom_range(40);
				if (b > DEPTH - 1) b = DEPTH - 1;
			end else if (sel < 88) begin
				a = $urandom_range(DEPTH - 1, 1);
				b = $urandom_range(a - 1);
			end else begin
				case ($urandom_range(4))
					0: begin a = 0; b = DEPTH - 1; end
					1: begin a = 0; b = 0; end
					2: begin a = DEPTH - 1; b = DEPTH - 1; end
					3: begin a = 0; b = DEPTH - 2; end
					default: begin a = 1; b = DEPTH - 1; end
				endcase
			end
			r = query_row(a, b, $urandom, DELTA_W'($urandom), 1'b0, '0);
		end
	endtask

	task automatic sender_idle(input int pct);
		while ($urandom_range(99) < pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic send_row(input stim_row_t r);
		@(negedge clk);
		start       <= 1'b1;
		req_type    <= r.req;
		position    <= r.pos;
		delta       <= r.dlt;
		range_low   <= r.lo;
		range_high  <= r.hi;
		cur_has_sum <= r.has_sum;
		cur_sum     <= r.sum;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
	endtask

	// scoreboard and model update, both on the rising edge
	always @(posedge clk) begin : score
		logic [SUM_W-1:0] want;
		logic [SUM_W-1:0] dext;
		if (done) begin
			if (pending_sums.size() == 0) begin
				$error("range_sum: no result expected, got %0d", range_sum);
				error_count++;
			end else begin
				want = pending_sums.pop_front();
				if (range_sum !== want) begin
					$error("range_sum: expected %0d, got %0d", $signed(want), range_sum);
					error_count++;
				end
			end
		end
		if (start && !busy) begin
			if (req_type == REQ_ADD) begin
				dext = {{(SUM_W - DELTA_W){delta[DELTA_W-1]}}, delta};
				if (position < DEPTH) begin
					entry_copy[position] <= entry_copy[position] + dext;
					block_copy[position / BLK] <= block_copy[position / BLK] + dext;
				end
			end else begin
				pending_sums.insert(pending_sums.size(), cur_has_sum ? cur_sum :
					range_total(32'(range_low), 32'(range_high)));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("block_range_sum_store_core verification failed");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		int pct;
		arst_n       = 1'b0;
		start        = 1'b0;
		req_type     = REQ_ADD;
		position     = '0;
		delta        = '0;
		range_low    = '0;
		range_high   = '0;
		cur_has_sum  = 1'b0;
		cur_sum      = '0;
		error_count  = 0;
		stall_cycles = 0;
		for (int i = 0; i < DEPTH; i++) entry_copy[i] = '0;
		for (int i = 0; i < NBLK; i++) block_copy[i] = '0;

		// all zero after reset, then single entries at the extremes
		stim_append(query_row(0, DEPTH - 1, 0, '0, 1'b1, 32'h0));
		stim_append(query_row(DEPTH - 1, DEPTH - 1, 10'h3FF, 16'hFFFF,
			1'b1, 32'h0));
		stim_append(add_row(0, 16'h7FFF));
		stim_append(add_row(DEPTH - 1, 16'h8000));
		stim_append(add_row(BLK - 1, 16'h0001));
		stim_append(add_row(BLK, 16'hFFFF));
		stim_append(query_row(0, 0, 10'h155, 16'h1234, 1'b1, 32'h0000_7FFF));
		stim_append(query_row(DEPTH - 1, DEPTH - 1, 0, '0, 1'b1,
			32'hFFFF_8000));
		stim_append(query_row(0, DEPTH - 1, 0, '0, 1'b0, '0));
		// empty ranges
		stim_append(query_row(5, 3, 0, '0, 1'b1, 32'h0));
		stim_append(query_row(DEPTH - 1, 0, 10'h2AA, 16'h8000, 1'b1, 32'h0));
		// block boundaries: adjacent partials, whole blocks, wide span
		stim_append(query_row(BLK - 1, BLK, 0, '0, 1'b0, '0));
		stim_append(query_row(0, BLK - 1, 0, '0, 1'b0, '0));
		stim_append(query_row(BLK, 2 * BLK - 1, 0, '0, 1'b0, '0));
		stim_append(query_row(1, DEPTH - 2, 0, '0, 1'b0, '0));
		stim_append(query_row(BLK - 2, BLK + 1, 0, '0, 1'b0, '0));
		stim_append(add_row(500, 16'h5555));
		stim_append(add_row(501, 16'hAAAA));
		stim_append(add_row(16 * BLK - 1, 16'h7FFF));
		stim_append(add_row(16 * BLK, 16'h8000));
		stim_append(query_row(15 * BLK, 17 * BLK - 1, 10'h3FF, 16'h7FFF,
			1'b0, '0));
		stim_append(query_row(500, 501, 0, '0, 1'b0, '0));
		stim_append(query_row(0, DEPTH - 1, 0, '0, 1'b0, '0));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) send_row(directed_rows[i]);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			pct = (phase == 0) ? 36 : (phase == 1) ? 65 : 0;
			repeat (PHASE_ITEMS) begin
				make_random_row(row);
				sender_idle(pct);
				send_row(row);
			end
			// hold the sender off until every query has answered
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("block_range_sum_store_core verification clean");
		else
			$display("block_range_sum_store_core verification failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/brss_pkg.sv
rtl/core/brss_front.sv
rtl/core/brss_queue.sv
rtl/core/brss_back.sv
rtl/core/block_range_sum_store_core.sv
sim/testbench.sv
